@@ rtl/core/lpht_pkg.sv @@
// ----------------------------------------------------------------------------
// Linear-probe hash table package
// Shared widths, status codes and controller states.
// ----------------------------------------------------------------------------
package lpht_pkg;

   localparam int CAPACITY_DEFAULT = 256;

   localparam int KEY_W    = 32;
   localparam int HASH_W   = 32;
   localparam int VALUE_W  = 64;
   localparam int STATUS_W = 3;

   // One table entry is {valid, key, value}.
   localparam int ENTRY_W  = 1 + KEY_W + VALUE_W;

   typedef enum logic [STATUS_W-1:0] {
      ST_FOUND     = 3'd0,
      ST_NOT_FOUND = 3'd1,
      ST_INSERTED  = 3'd2,
      ST_UPDATED   = 3'd3,
      ST_FULL      = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      S_CLEAR,
      S_IDLE,
      S_CHECK
   } state_type;

endpackage

@@ rtl/core/lpht_ram.sv @@
// ----------------------------------------------------------------------------
// Linear-probe hash table RAM
// Simple dual-port synchronous RAM with one write port and a registered read.
// ----------------------------------------------------------------------------
module lpht_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

@@ rtl/core/linear_probe_hash_table.sv @@
// ----------------------------------------------------------------------------
// Linear-probe hash table
// Fixed-capacity open-addressing key/value store with linear probing.
// ----------------------------------------------------------------------------
// A transaction is accepted when start is high and busy is low. A get returns
// the stored value or not found; a set updates an existing key or inserts a
// new one, and a new key is refused with status full once the table holds
// three quarters of CAPACITY entries. A transaction probes slots in turn from
// its home slot, one read of the single table RAM per cycle. The result shows
// on the rsp_ ports for exactly one cycle, marked by rsp_valid, in the cycle
// after the last probe, and the receiver cannot hold it off. busy drops in
// that same cycle, so the next transaction can be accepted while the result
// is on the ports. After reset the block runs a clearing pass, one table
// entry per cycle, and keeps busy high throughout.
// ----------------------------------------------------------------------------
module linear_probe_hash_table
   import lpht_pkg::*;
#(
   parameter int CAPACITY = CAPACITY_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,

   input  logic                start,
   output logic                busy,
   input  logic                req_action,
   input  logic [KEY_W-1:0]    req_key_id,
   input  logic [HASH_W-1:0]   req_key_hash,
   input  logic [VALUE_W-1:0]  req_write_value,

   output logic                rsp_valid,
   output logic [STATUS_W-1:0] rsp_status,
   output logic [VALUE_W-1:0]  rsp_read_value
);

   // Index width, and a count width that can hold CAPACITY itself.
   localparam int IW = $clog2(CAPACITY);
   localparam int CW = IW + 1;

   // A new key is refused when 4*(count+1) > 3*CAPACITY, that is when the
   // count has already reached three quarters of CAPACITY.
   localparam logic [CW-1:0] LOAD_LIMIT = CW'(3 * CAPACITY / 4);
   localparam logic [IW-1:0] LAST_SLOT  = IW'(CAPACITY - 1);
   localparam logic [IW-1:0] ONE_SLOT   = IW'(1);

   state_type            state_ff, state_in;
   // The slot index doubles as the address counter of the clearing pass.
   logic [IW-1:0]        idx_ff, idx_in;
   logic [IW-1:0]        probe_ff, probe_in;
   logic [CW-1:0]        count_ff, count_in;

   logic                 act_ff, act_in;
   logic [KEY_W-1:0]     key_ff, key_in;
   logic [VALUE_W-1:0]   wval_ff, wval_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   status_type           rsp_status_ff, rsp_status_in;
   logic [VALUE_W-1:0]   rsp_value_ff, rsp_value_in;

   logic                 ram_we;
   logic [IW-1:0]        ram_waddr;
   logic [ENTRY_W-1:0]   ram_wdata;
   logic [IW-1:0]        ram_raddr;
   logic [ENTRY_W-1:0]   ram_rdata;

   logic                 rd_valid;
   logic [KEY_W-1:0]     rd_key;
   logic [VALUE_W-1:0]   rd_value;
   logic                 rd_match;

   // The valid bit lives in the RAM next to key and value, so the clearing
   // pass after reset is what empties the table.
   lpht_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (CAPACITY)
   ) u_table (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   assign rd_valid = ram_rdata[ENTRY_W-1];
   assign rd_key   = ram_rdata[VALUE_W +: KEY_W];
   assign rd_value = ram_rdata[VALUE_W-1:0];
   assign rd_match = rd_valid && (rd_key == key_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         idx_ff       <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      probe_ff      <= probe_in;
      act_ff        <= act_in;
      key_ff        <= key_in;
      wval_ff       <= wval_in;
      rsp_status_ff <= rsp_status_in;
      rsp_value_ff  <= rsp_value_in;
   end

   // Outside the clearing pass, the RAM is written only in the cycle that resolves
   // a transaction, and the next read is issued no earlier than the following
   // cycle, so a read never overlaps a pending write to the same entry.
   always_comb begin
      state_in      = state_ff;
      idx_in        = idx_ff;
      probe_in      = probe_ff;
      count_in      = count_ff;
      act_in        = act_ff;
      key_in        = key_ff;
      wval_in       = wval_ff;
      rsp_valid_in  = 1'b0;
      rsp_status_in = rsp_status_ff;
      rsp_value_in  = rsp_value_ff;
      ram_we        = 1'b0;
      ram_waddr     = idx_ff;
      ram_wdata     = {1'b1, key_ff, wval_ff};
      ram_raddr     = idx_ff + ONE_SLOT;

      unique case (state_ff)
         S_CLEAR: begin
            ram_we    = 1'b1;
            ram_wdata = '0;
            if (idx_ff == LAST_SLOT) begin
               state_in = S_IDLE;
               idx_in   = '0;
            end else begin
               idx_in = idx_ff + ONE_SLOT;
            end
         end

         S_IDLE: begin
            if (start) begin
               act_in    = req_action;
               key_in    = req_key_id;
               wval_in   = req_write_value;
               idx_in    = req_key_hash[IW-1:0];
               ram_raddr = req_key_hash[IW-1:0];
               probe_in  = '0;
               state_in  = S_CHECK;
            end
         end

         S_CHECK: begin
            if (!rd_valid || rd_match) begin
               // Probe ends on the key itself or on an empty slot.
               state_in     = S_IDLE;
               rsp_valid_in = 1'b1;
               rsp_value_in = '0;
               if (!act_ff) begin
                  if (rd_match) begin
                     rsp_status_in = ST_FOUND;
                     rsp_value_in  = rd_value;
                  end else begin
                     rsp_status_in = ST_NOT_FOUND;
                  end
               end else if (rd_match) begin
                  ram_we        = 1'b1;
                  rsp_status_in = ST_UPDATED;
               end else if (count_ff >= LOAD_LIMIT) begin
                  rsp_status_in = ST_FULL;
               end else begin
                  ram_we        = 1'b1;
                  count_in      = count_ff + CW'(1);
                  rsp_status_in = ST_INSERTED;
               end
            end else if (probe_ff == LAST_SLOT) begin
               // Every slot visited without a hit or a hole.
               state_in      = S_IDLE;
               rsp_valid_in  = 1'b1;
               rsp_value_in  = '0;
               rsp_status_in = act_ff ? ST_FULL : ST_NOT_FOUND;
            end else begin
               // Next slot, wrapping round; its read is already issued.
               idx_in   = idx_ff + ONE_SLOT;
               probe_in = probe_ff + ONE_SLOT;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign busy           = (state_ff != S_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_read_value = rsp_value_ff;

endmodule

@@ rtl/core/lpht_checker.sv @@
// ----------------------------------------------------------------------------
// Linear-probe hash table checker
// Port-level assertions on transactions and results, bound to the top level.
// ----------------------------------------------------------------------------
module lpht_checker
   import lpht_pkg::*;
(
   input logic                clock,
   input logic                reset,
   input logic                start,
   input logic                busy,
   input logic                rsp_valid,
   input logic [STATUS_W-1:0] rsp_status,
   input logic [VALUE_W-1:0]  rsp_read_value
);

   // An accepted transaction always raises busy.
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted transaction did not raise busy");

   // A result comes only out of a cycle in which work was in progress.
   a_result_after_work: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy))
      else $error("result without a transaction in progress");

   // Two results are never adjacent: each transaction needs a probe in between.
   a_single_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe held for more than one cycle");

   // Only a found result carries a value.
   a_value_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status != ST_FOUND)) |-> (rsp_read_value == '0))
      else $error("nonzero value on a result other than found");

endmodule

bind linear_probe_hash_table lpht_checker u_lpht_checker (
   .clock          (clock),
   .reset          (reset),
   .start          (start),
   .busy           (busy),
   .rsp_valid      (rsp_valid),
   .rsp_status     (rsp_status),
   .rsp_read_value (rsp_read_value)
);

@@ verif/tb_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Linear-probe hash table testbench
// Drives get and set transactions into the table and checks every result
// against a predictor that keeps its own copy of the slots. Directed
// transactions cover the empty table, wraparound and updates. Random
// transactions then fill the table through clustered home slots up to and
// past its load limit, with sender gaps that vary by phase.
// ----------------------------------------------------------------------------
module tb_top;
   import lpht_pkg::*;

   // The block is built with its default capacity, so the predictor uses it too.
   localparam int TABLE_SLOTS = CAPACITY_DEFAULT;
   localparam int SLOT_MASK   = TABLE_SLOTS - 1;
   // Largest entry count that the three-quarter load limit lets in.
   localparam int LOAD_LIMIT  = (3 * TABLE_SLOTS) / 4;
   localparam int RANDOM_OPS  = 900;
   localparam int DRAIN_WAIT  = 300;
   localparam int MAX_REPORTS = 10;

   localparam logic ACT_GET = 1'b0;
   localparam logic ACT_SET = 1'b1;

   typedef struct {
      logic               action;
      logic [KEY_W-1:0]   key_id;
      logic [HASH_W-1:0]  key_hash;
      logic [VALUE_W-1:0] write_value;
   } table_op_type;

   typedef struct {
      status_type         status;
      logic [VALUE_W-1:0] read_value;
   } lookup_result_type;

   typedef struct {
      logic [KEY_W-1:0]  key_id;
      logic [HASH_W-1:0] key_hash;
   } known_key_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                start = 1'b0;
   logic                busy;
   logic                req_action = 1'b0;
   logic [KEY_W-1:0]    req_key_id = '0;
   logic [HASH_W-1:0]   req_key_hash = '0;
   logic [VALUE_W-1:0]  req_write_value = '0;
   logic                rsp_valid;
   logic [STATUS_W-1:0] rsp_status;
   logic [VALUE_W-1:0]  rsp_read_value;

   // Transactions waiting to be sent, and results owed by the block in order.
   table_op_type      pending_ops[$];
   lookup_result_type expected_results[$];
   // Keys that the stimulus has already used, so later transactions can hit them.
   known_key_type     known_keys[$];

   int total_ops    = 0;
   int accepted_ops = 0;
   int new_key_sets = 0;
   int error_count  = 0;

   // Predictor copy of the table contents.
   logic               pred_valid[TABLE_SLOTS];
   logic [KEY_W-1:0]   pred_key[TABLE_SLOTS];
   logic [VALUE_W-1:0] pred_value[TABLE_SLOTS];
   int                 pred_count = 0;

   linear_probe_hash_table u_top (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_action      (req_action),
      .req_key_id      (req_key_id),
      .req_key_hash    (req_key_hash),
      .req_write_value (req_write_value),
      .rsp_valid       (rsp_valid),
      .rsp_status      (rsp_status),
      .rsp_read_value  (rsp_read_value)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Only the valid bits need clearing: keys and values are read behind them.
   initial begin
      for (int i = 0; i < TABLE_SLOTS; i++) begin
         pred_valid[i] = 1'b0;
         pred_key[i]   = '0;
         pred_value[i] = '0;
      end
   end

   // Applies one transaction to the predicted table and returns the result
   // the block owes for it. The probe walks from the home slot with
   // wraparound until it meets the same key or an empty slot.
   function automatic lookup_result_type table_predict(input table_op_type op);
      lookup_result_type res;
      int                slot;
      bit                hit;
      slot = op.key_hash & SLOT_MASK;
      hit  = 1'b0;
      res.status     = ST_NOT_FOUND;
      res.read_value = '0;
      for (int n = 0; n < TABLE_SLOTS && !hit; n++) begin
         if (!pred_valid[slot] || pred_key[slot] == op.key_id)
            hit = 1'b1;
         else
            slot = (slot + 1) & SLOT_MASK;
      end
      if (op.action == ACT_GET) begin
         if (pred_count != 0 && hit && pred_valid[slot]) begin
            res.status     = ST_FOUND;
            res.read_value = pred_value[slot];
         end
      end else if (hit && pred_valid[slot]) begin
         // An existing key is always updated, even at the load limit.
         pred_value[slot] = op.write_value;
         res.status       = ST_UPDATED;
      end else if (!hit || 4 * (pred_count + 1) > 3 * TABLE_SLOTS) begin
         // Refusal leaves the table untouched.
         res.status = ST_FULL;
      end else begin
         pred_valid[slot] = 1'b1;
         pred_key[slot]   = op.key_id;
         pred_value[slot] = op.write_value;
         pred_count++;
         res.status = ST_INSERTED;
      end
      return res;
   endfunction

   task automatic report_error(input string msg);
      error_count++;
      if (error_count <= MAX_REPORTS)
         $display("ERROR at %0t: %s", $realtime, msg);
   endtask

   task automatic push_op(input logic act, input logic [KEY_W-1:0] kid,
                          input logic [HASH_W-1:0] kh, input logic [VALUE_W-1:0] wv);
      table_op_type op;
      op.action      = act;
      op.key_id      = kid;
      op.key_hash    = kh;
      op.write_value = wv;
      pending_ops.push_back(op);
   endtask

   // Roughly a third of the new keys land on a few home slots around the top
   // of the table, which builds long probe chains that wrap past slot zero.
   function automatic logic [HASH_W-1:0] pick_hash();
      logic [HASH_W-1:0] h;
      logic [7:0]        low;
      h = $urandom;
      if ($urandom_range(0, 99) < 30) begin
         low = 8'hFC;
         low = low + 8'($urandom_range(0, 7));
         h[7:0] = low;
      end
      return h;
   endfunction

   function automatic logic [VALUE_W-1:0] pick_value();
      int r;
      r = $urandom_range(0, 99);
      if (r < 8)
         return '0;
      else if (r < 16)
         return '1;
      return {$urandom, $urandom};
   endfunction

   // Sends a set of a brand new key and remembers it for later hits.
   task automatic push_new_key_set();
      known_key_type k;
      k.key_id   = $urandom;
      k.key_hash = pick_hash();
      known_keys.push_back(k);
      new_key_sets++;
      push_op(ACT_SET, k.key_id, k.key_hash, pick_value());
   endtask

   task automatic fill_stimulus();
      known_key_type k;
      int            r;
      int            fill_left;

      // Directed part. A get on the empty table must miss, whatever the key.
      push_op(ACT_GET, 32'h0, 32'h0, 64'h0);
      push_op(ACT_GET, '1, '1, '1);
      // Keys at both ends of the slot range, then a collision at the top slot
      // that has to wrap round past slot zero.
      push_op(ACT_SET, 32'h0, 32'h0, 64'h0);
      push_op(ACT_GET, 32'h0, 32'h0, '1);
      push_op(ACT_SET, '1, '1, '1);
      push_op(ACT_SET, 32'h1, 32'h0000_01FF, 64'h0123_4567_89AB_CDEF);
      push_op(ACT_GET, 32'h1, 32'h0000_01FF, 64'h0);
      push_op(ACT_GET, '1, '1, 64'h5555_5555_5555_5555);
      // Update in place, then read the new value back.
      push_op(ACT_SET, 32'h0, 32'h0, 64'hFEDC_BA98_7654_3210);
      push_op(ACT_GET, 32'h0, 32'h0, 64'h0);
      push_op(ACT_SET, 32'h1, 32'hFFFF_FEFF, 64'hAAAA_AAAA_AAAA_AAAA);
      push_op(ACT_GET, 32'h1, 32'h0000_01FF, 64'h0);
      // A miss whose probe crosses the whole wrapped chain, and a known key
      // looked up under a different home slot.
      push_op(ACT_GET, 32'h2, 32'h0000_00FF, 64'h0);
      push_op(ACT_GET, 32'h1, 32'h0000_0080, 64'h0);
      push_op(ACT_GET, 32'h8000_0000, 32'h8000_0000, 64'h0);
      k.key_id = 32'h0; k.key_hash = 32'h0;          known_keys.push_back(k);
      k.key_id = '1;    k.key_hash = '1;             known_keys.push_back(k);
      k.key_id = 32'h1; k.key_hash = 32'h0000_01FF;  known_keys.push_back(k);
      new_key_sets = 3;

      // Random part: mostly sets and gets of known keys while the table fills.
      for (int i = 0; i < RANDOM_OPS; i++) begin
         r = $urandom_range(0, 99);
         if (r < 60) begin
            if ($urandom_range(0, 1) == 0) begin
               push_new_key_set();
            end else begin
               k = known_keys[$urandom_range(0, known_keys.size() - 1)];
               push_op(ACT_SET, k.key_id, k.key_hash, pick_value());
            end
         end else if (r < 88) begin
            k = known_keys[$urandom_range(0, known_keys.size() - 1)];
            push_op(ACT_GET, k.key_id, k.key_hash, pick_value());
         end else if (r < 95) begin
            // Absent key: a miss that walks whatever chain its home slot has.
            push_op(ACT_GET, $urandom, pick_hash(), pick_value());
         end else begin
            // Broken lookup: a known key under a hash it was never stored with.
            k = known_keys[$urandom_range(0, known_keys.size() - 1)];
            push_op(ACT_GET, k.key_id, $urandom, pick_value());
         end
      end

      // Make sure the load limit is reached and passed, then update an
      // existing key while the table is at the limit.
      fill_left = LOAD_LIMIT - new_key_sets + 4;
      for (int i = 0; i < fill_left; i++)
         push_new_key_set();
      push_op(ACT_SET, 32'h0, 32'h0, pick_value());
      push_op(ACT_GET, 32'h0, 32'h0, 64'h0);
      push_new_key_set();
      k = known_keys[known_keys.size() - 1];
      push_op(ACT_GET, k.key_id, k.key_hash, 64'h0);
      push_op(ACT_SET, '1, '1, 64'h0);
      push_op(ACT_GET, '1, '1, '1);
   endtask

   // Driver. A transaction stays on the req_ ports with start high until the
   // block takes it; the predictor runs at the edge of acceptance so the
   // expected results line up with the order the block works in. Gaps are
   // only inserted between transactions.
   always @(posedge clock) begin
      int idle_pct;
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy) begin
            expected_results.push_back(table_predict(pending_ops[0]));
            void'(pending_ops.pop_front());
            accepted_ops++;
         end
         if (!start || !busy) begin
            if (accepted_ops < total_ops / 3)
               idle_pct = 28;
            else if (accepted_ops < (2 * total_ops) / 3)
               idle_pct = 65;
            else
               idle_pct = 0;
            if (pending_ops.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
               start           <= 1'b1;
               req_action      <= pending_ops[0].action;
               req_key_id      <= pending_ops[0].key_id;
               req_key_hash    <= pending_ops[0].key_hash;
               req_write_value <= pending_ops[0].write_value;
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   // Monitor. Each strobed result is checked against the oldest expectation.
   always @(posedge clock) begin
      lookup_result_type exp_res;
      if (!reset && rsp_valid === 1'b1) begin
         if (expected_results.size() == 0) begin
            report_error($sformatf("result with no transaction outstanding: status %0d value %h",
                                   rsp_status, rsp_read_value));
         end else begin
            exp_res = expected_results.pop_front();
            if (rsp_status !== exp_res.status || rsp_read_value !== exp_res.read_value)
               report_error($sformatf("status exp %0d got %0d, value exp %h got %h",
                                      exp_res.status, rsp_status,
                                      exp_res.read_value, rsp_read_value));
         end
      end
   end

   // Watchdog. The slowest legal run is about a thousand transactions each
   // probing the whole table after long sender gaps, well under this bound.
   initial begin
      #10_000_000;
      $display("DONE: errors detected");
      $finish;
   end

   initial begin
      fill_stimulus();
      total_ops = pending_ops.size();
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      // The block clears its table after reset with busy high; the driver
      // simply waits that out through the handshake.
      while (pending_ops.size() != 0 || start)
         @(posedge clock);
      while (expected_results.size() != 0)
         @(posedge clock);
      // Leave room for any stray result that would still come out.
      repeat (DRAIN_WAIT) @(posedge clock);
      if (error_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule

@@ filelist.f @@
rtl/core/lpht_pkg.sv
rtl/core/lpht_ram.sv
rtl/core/linear_probe_hash_table.sv
rtl/core/lpht_checker.sv
verif/tb_top.sv
